### rtl/block_transposition_cipher_macros.svh
// assertion macros for the block transposition cipher
// used by block_transposition_cipher.sv, expects clk_i and rst_ni in scope
`ifndef BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH
`define BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH
`ifndef SYNTH
`define BTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btc assertion failed");
`define BTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btc assertion failed");
`define BTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btc assertion failed");
`else
`define BTC_ASSERT(lbl, prop)
`define BTC_ASSERT_IMP(lbl, ante, cons)
`define BTC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/btc_pkg.sv
// constants and types for the block transposition cipher
// no dependencies
`timescale 1ns / 1ps
package btc_pkg;
  localparam int BLOCK_LEN     = 10;
  localparam int TABLE_ENTRIES = 10;
  localparam int ENTRY_W       = 4;
  localparam int PERM_W        = TABLE_ENTRIES * ENTRY_W;
  localparam int IDX_W         = $clog2(BLOCK_LEN);
  localparam int CNT_W         = $clog2(BLOCK_LEN + 1);
  localparam int SRC_W         = (ENTRY_W > IDX_W) ? ENTRY_W + 1 : IDX_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = PERM_W;

  localparam logic [CFG_IDX_W-1:0] REG_PERM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD  = 1'd1;

  localparam logic [7:0]        SPACE_CHAR = 8'd32;
  localparam logic [PERM_W-1:0] RESET_PERM = 40'd98939975205;
  localparam logic [7:0]        RESET_PAD  = 8'd42;

  typedef logic [7:0] byte_t;
endpackage

### rtl/block_transposition_cipher.sv
// Block transposition cipher: spaces are dropped, other bytes are gathered into
// blocks of BLOCK_LEN and sent out permuted, one byte per cycle on each side.
// A block is loaded into the output buffer in the cycle its last byte is taken
// (or when end of message flushes a padded partial block) and leaves one byte
// at a time while the next block is gathered in parallel. Sustained rate
// is one item per cycle for full blocks. A completed block that finds the
// output buffer still busy waits in the gather buffer and stalls the input
// until the buffer frees; this happens when the output side is back-pressured
// and also when end of message flushes a short block right behind one that is
// still being sent, since one input item can then cause BLOCK_LEN results.
// Depends on btc_pkg and block_transposition_cipher_macros.svh.
`timescale 1ns / 1ps
`include "block_transposition_cipher_macros.svh"
module block_transposition_cipher
  import btc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // message_byte
  input  logic                  s_axis_tlast,   // end_of_message
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // cipher_byte
  output logic                  m_axis_tlast,   // last_of_block
  output logic                  m_axis_tuser    // last_of_message
);

  logic [PERM_W-1:0] perm_q;
  byte_t             pad_q;

  byte_t             buf_q  [BLOCK_LEN];
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              pend_q, pend_d;
  logic              pend_fin_q, pend_fin_d;

  byte_t             emit_q [BLOCK_LEN];
  byte_t             emit_d [BLOCK_LEN];
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic              busy_q, busy_d;
  logic              fin_q, fin_d;

  logic              acc, nonsp, insert, complete_in, finishing, emit_free, load;
  logic [CNT_W-1:0]  fill_inc;
  byte_t             blk [BLOCK_LEN];
  logic [SRC_W-1:0]  src [BLOCK_LEN];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_q <= RESET_PERM;
      pad_q  <= RESET_PAD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERM: perm_q <= cfg_data_i[PERM_W-1:0];
        REG_PAD:  pad_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !pend_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign nonsp         = s_axis_tdata != SPACE_CHAR;
  assign fill_inc      = fill_q + CNT_W'(nonsp);
  assign complete_in   = acc && ((fill_inc == CNT_W'(BLOCK_LEN)) ||
                                 (s_axis_tlast && (fill_inc != '0)));
  assign finishing     = busy_q && m_axis_tready && (pos_q == IDX_W'(BLOCK_LEN - 1));
  assign emit_free     = !busy_q || finishing;
  assign load          = emit_free && (pend_q || complete_in);
  assign insert        = !pend_q && acc && nonsp;

  // padded block and its permutation
  always_comb begin
    for (int i = 0; i < BLOCK_LEN; i++) begin
      if (CNT_W'(i) < fill_q) begin
        blk[i] = buf_q[i];
      end else if (insert && (CNT_W'(i) == fill_q)) begin
        blk[i] = s_axis_tdata;
      end else begin
        blk[i] = pad_q;
      end
    end
    for (int p = 0; p < BLOCK_LEN; p++) begin
      if (p < TABLE_ENTRIES) begin
        src[p] = SRC_W'(perm_q[ENTRY_W*p +: ENTRY_W]);
      end else begin
        src[p] = SRC_W'(p);
      end
      if (src[p] < SRC_W'(BLOCK_LEN)) begin
        emit_d[p] = blk[src[p][IDX_W-1:0]];
      end else begin
        emit_d[p] = pad_q;
      end
    end
  end

  always_comb begin
    fill_d     = fill_q;
    pend_d     = pend_q;
    pend_fin_d = pend_fin_q;
    pos_d      = pos_q;
    busy_d     = busy_q;
    fin_d      = fin_q;
    if (busy_q && m_axis_tready) begin
      if (finishing) begin
        busy_d = 1'b0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + IDX_W'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
      fin_d  = pend_q ? pend_fin_q : s_axis_tlast;
      fill_d = '0;
      pend_d = 1'b0;
    end else if (complete_in) begin
      pend_d     = 1'b1;
      pend_fin_d = s_axis_tlast;
      fill_d     = fill_inc;
    end else if (acc) begin
      fill_d = fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pend_q     <= 1'b0;
      pend_fin_q <= 1'b0;
      pos_q      <= '0;
      busy_q     <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      pend_q     <= pend_d;
      pend_fin_q <= pend_fin_d;
      pos_q      <= pos_d;
      busy_q     <= busy_d;
      fin_q      <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      buf_q[fill_q[IDX_W-1:0]] <= s_axis_tdata;
    end
    if (load) begin
      emit_q <= emit_d;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = emit_q[pos_q];
  assign m_axis_tlast  = pos_q == IDX_W'(BLOCK_LEN - 1);
  assign m_axis_tuser  = fin_q && m_axis_tlast;

  `BTC_ASSERT_IMP(a_pend_busy, pend_q, busy_q && fill_q != '0)
  `BTC_ASSERT(a_fill_range, fill_q <= CNT_W'(BLOCK_LEN))
  `BTC_ASSERT_IMP(a_pos_idle, !busy_q, pos_q == '0)
  `BTC_ASSERT_NXT(a_load_start, load, m_axis_tvalid && pos_q == '0 && fill_q == '0)

endmodule
